// ===== hw/rtl/cau_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, widths, operation codes and the saturation helper of the
// complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int WORD_BITS     = 32;
   localparam int FRACTION_BITS = 16;
   localparam int PROD_BITS     = 2 * WORD_BITS;
   localparam int SUM_BITS      = 2 * WORD_BITS + 1;
   localparam int NUM_BITS      = PROD_BITS + FRACTION_BITS;
   localparam int ROOT_REM_BITS = WORD_BITS + 2;

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_NEG  = 3'd4,
      OP_CONJ = 3'd5,
      OP_MAG  = 3'd6
   } cau_op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_SATURATED = 2'd1,
      ST_DIV_ZERO  = 2'd2
   } cau_status_type;

   typedef struct packed {
      logic [2:0]           operation;
      logic [WORD_BITS-1:0] a_re;
      logic [WORD_BITS-1:0] a_im;
      logic [WORD_BITS-1:0] b_re;
      logic [WORD_BITS-1:0] b_im;
   } cau_req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] result_re;
      logic [WORD_BITS-1:0] result_im;
      logic [1:0]           status;
   } cau_rsp_type;

   // products and the short add/sub/negate/conjugate values
   typedef struct packed {
      logic                 valid;
      logic [2:0]           op;
      logic [PROD_BITS-1:0] rr;
      logic [PROD_BITS-1:0] ii;
      logic [PROD_BITS-1:0] ri;
      logic [PROD_BITS-1:0] ir;
      logic [PROD_BITS-1:0] sx;
      logic [PROD_BITS-1:0] sy;
      logic [WORD_BITS:0]   simp_re;
      logic [WORD_BITS:0]   simp_im;
   } cau_prod_type;

   typedef struct packed {
      logic                 valid;
      logic [2:0]           op;
      logic [SUM_BITS-1:0]  mre;
      logic [SUM_BITS-1:0]  mim;
      logic [SUM_BITS-1:0]  nre;
      logic [SUM_BITS-1:0]  nim;
      logic [PROD_BITS-1:0] sq;
      logic [WORD_BITS:0]   simp_re;
      logic [WORD_BITS:0]   simp_im;
   } cau_sum_type;

   // state carried through the divide / square-root iterations
   typedef struct packed {
      logic                     valid;
      logic [2:0]               op;
      logic [WORD_BITS-1:0]     fix_re;
      logic [WORD_BITS-1:0]     fix_im;
      logic                     fix_sat;
      logic                     dz;
      logic                     ovf_re;
      logic                     ovf_im;
      logic                     neg_re;
      logic                     neg_im;
      logic [PROD_BITS-1:0]     den;
      logic [PROD_BITS-1:0]     rem_re;
      logic [PROD_BITS-1:0]     rem_im;
      logic [WORD_BITS-1:0]     low_re;
      logic [WORD_BITS-1:0]     low_im;
      logic [WORD_BITS-1:0]     q_re;
      logic [WORD_BITS-1:0]     q_im;
      logic [PROD_BITS-1:0]     sq_x;
      logic [ROOT_REM_BITS-1:0] sq_rem;
      logic [WORD_BITS-1:0]     sq_root;
   } cau_work_type;

   typedef struct packed {
      logic                 sat;
      logic [WORD_BITS-1:0] value;
   } cau_sat_type;

   function automatic cau_sat_type sat_word(input logic [SUM_BITS-1:0] v);
      logic signed [SUM_BITS-1:0] hi;
      logic signed [SUM_BITS-1:0] lo;
      cau_sat_type                r;
      hi = {{(SUM_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
      lo = {{(SUM_BITS-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};
      r.sat   = 1'b0;
      r.value = v[WORD_BITS-1:0];
      if ($signed(v) > hi) begin
         r.sat   = 1'b1;
         r.value = hi[WORD_BITS-1:0];
      end else if ($signed(v) < lo) begin
         r.sat   = 1'b1;
         r.value = lo[WORD_BITS-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cau_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_front
// Two stages: the operand products, then the cross sums of the products.
// ----------------------------------------------------------------------------
module cau_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire cau_pkg::cau_req_type in_data,
   output cau_pkg::cau_sum_type     out_sum
);

   localparam int W = cau_pkg::WORD_BITS;

   cau_pkg::cau_prod_type prod_ff, prod_in;
   cau_pkg::cau_sum_type  sum_ff, sum_in;

   logic signed [W-1:0] ar, ai, br, bi, sxa, sya;
   logic signed [W:0]   ear, eai, ebr, ebi;

   always_comb begin
      ar  = $signed(in_data.a_re);
      ai  = $signed(in_data.a_im);
      br  = $signed(in_data.b_re);
      bi  = $signed(in_data.b_im);
      ear = {ar[W-1], ar};
      eai = {ai[W-1], ai};
      ebr = {br[W-1], br};
      ebi = {bi[W-1], bi};
      // squared magnitude of a for |a|, of b for the divisor
      sxa = (in_data.operation == cau_pkg::OP_MAG) ? ar : br;
      sya = (in_data.operation == cau_pkg::OP_MAG) ? ai : bi;

      prod_in.valid = in_valid;
      prod_in.op    = in_data.operation;
      prod_in.rr    = ar * br;
      prod_in.ii    = ai * bi;
      prod_in.ri    = ar * bi;
      prod_in.ir    = ai * br;
      prod_in.sx    = sxa * sxa;
      prod_in.sy    = sya * sya;
      case (in_data.operation)
         cau_pkg::OP_ADD: begin
            prod_in.simp_re = ear + ebr;
            prod_in.simp_im = eai + ebi;
         end
         cau_pkg::OP_SUB: begin
            prod_in.simp_re = ear - ebr;
            prod_in.simp_im = eai - ebi;
         end
         cau_pkg::OP_NEG: begin
            prod_in.simp_re = -ear;
            prod_in.simp_im = -eai;
         end
         cau_pkg::OP_CONJ: begin
            prod_in.simp_re = ear;
            prod_in.simp_im = -eai;
         end
         default: begin
            prod_in.simp_re = '0;
            prod_in.simp_im = '0;
         end
      endcase
   end

   always_comb begin
      sum_in.valid   = prod_ff.valid;
      sum_in.op      = prod_ff.op;
      sum_in.mre     = {prod_ff.rr[2*W-1], prod_ff.rr} - {prod_ff.ii[2*W-1], prod_ff.ii};
      sum_in.mim     = {prod_ff.ri[2*W-1], prod_ff.ri} + {prod_ff.ir[2*W-1], prod_ff.ir};
      sum_in.nre     = {prod_ff.rr[2*W-1], prod_ff.rr} + {prod_ff.ii[2*W-1], prod_ff.ii};
      sum_in.nim     = {prod_ff.ir[2*W-1], prod_ff.ir} - {prod_ff.ri[2*W-1], prod_ff.ri};
      sum_in.sq      = prod_ff.sx + prod_ff.sy;
      sum_in.simp_re = prod_ff.simp_re;
      sum_in.simp_im = prod_ff.simp_im;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff <= '0;
         sum_ff  <= '0;
      end else begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
      end
   end

   assign out_sum = sum_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/cau_setup.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_setup
// Finishes the short operations and prepares the divide and root iterations.
// ----------------------------------------------------------------------------
module cau_setup (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cau_pkg::cau_sum_type in_sum,
   output cau_pkg::cau_work_type     out_work
);

   localparam int W  = cau_pkg::WORD_BITS;
   localparam int F  = cau_pkg::FRACTION_BITS;
   localparam int P  = cau_pkg::PROD_BITS;
   localparam int S  = cau_pkg::SUM_BITS;
   localparam int NB = cau_pkg::NUM_BITS;

   cau_pkg::cau_work_type work_ff, work_in;
   cau_pkg::cau_sat_type  s_re, s_im;
   logic [S-1:0]          v_re, v_im, abs_re, abs_im;
   logic [NB-1:0]         n_re, n_im;
   logic [P-1:0]          top_re, top_im;

   always_comb begin
      if (in_sum.op == cau_pkg::OP_MUL) begin
         // arithmetic shift of two's complement is the floor
         v_re = $signed(in_sum.mre) >>> F;
         v_im = $signed(in_sum.mim) >>> F;
      end else begin
         v_re = {{(S-W-1){in_sum.simp_re[W]}}, in_sum.simp_re};
         v_im = {{(S-W-1){in_sum.simp_im[W]}}, in_sum.simp_im};
      end
      s_re = cau_pkg::sat_word(v_re);
      s_im = cau_pkg::sat_word(v_im);

      abs_re = in_sum.nre[S-1] ? -in_sum.nre : in_sum.nre;
      abs_im = in_sum.nim[S-1] ? -in_sum.nim : in_sum.nim;
      n_re   = {abs_re[P-1:0], {F{1'b0}}};
      n_im   = {abs_im[P-1:0], {F{1'b0}}};
      top_re = P'(n_re[NB-1:W]);
      top_im = P'(n_im[NB-1:W]);

      work_in.valid   = in_sum.valid;
      work_in.op      = in_sum.op;
      work_in.fix_re  = s_re.value;
      work_in.fix_im  = s_im.value;
      work_in.fix_sat = s_re.sat | s_im.sat;
      work_in.dz      = (in_sum.sq == '0);
      // quotient would need more than a word
      work_in.ovf_re  = (top_re >= in_sum.sq);
      work_in.ovf_im  = (top_im >= in_sum.sq);
      work_in.neg_re  = in_sum.nre[S-1];
      work_in.neg_im  = in_sum.nim[S-1];
      work_in.den     = in_sum.sq;
      work_in.rem_re  = top_re;
      work_in.rem_im  = top_im;
      work_in.low_re  = n_re[W-1:0];
      work_in.low_im  = n_im[W-1:0];
      work_in.q_re    = '0;
      work_in.q_im    = '0;
      work_in.sq_x    = in_sum.sq;
      work_in.sq_rem  = '0;
      work_in.sq_root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff <= '0;
      end else begin
         work_ff <= work_in;
      end
   end

   assign out_work = work_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/cau_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_step
// One registered iteration: a quotient bit for each divide lane and one
// root bit for the square root.
// ----------------------------------------------------------------------------
module cau_step (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cau_pkg::cau_work_type in_work,
   output cau_pkg::cau_work_type      out_work
);

   localparam int W  = cau_pkg::WORD_BITS;
   localparam int P  = cau_pkg::PROD_BITS;
   localparam int RB = cau_pkg::ROOT_REM_BITS;

   cau_pkg::cau_work_type work_ff, work_in;
   logic [P:0]    r2_re, r2_im, dd;
   logic [RB+1:0] r4, t;

   always_comb begin
      work_in = in_work;
      dd      = {1'b0, in_work.den};

      r2_re = {in_work.rem_re, in_work.low_re[W-1]};
      r2_im = {in_work.rem_im, in_work.low_im[W-1]};
      work_in.low_re = {in_work.low_re[W-2:0], 1'b0};
      work_in.low_im = {in_work.low_im[W-2:0], 1'b0};
      if (r2_re >= dd) begin
         work_in.rem_re = P'(r2_re - dd);
         work_in.q_re   = {in_work.q_re[W-2:0], 1'b1};
      end else begin
         work_in.rem_re = r2_re[P-1:0];
         work_in.q_re   = {in_work.q_re[W-2:0], 1'b0};
      end
      if (r2_im >= dd) begin
         work_in.rem_im = P'(r2_im - dd);
         work_in.q_im   = {in_work.q_im[W-2:0], 1'b1};
      end else begin
         work_in.rem_im = r2_im[P-1:0];
         work_in.q_im   = {in_work.q_im[W-2:0], 1'b0};
      end

      r4 = {in_work.sq_rem, in_work.sq_x[P-1:P-2]};
      t  = (RB+2)'({in_work.sq_root, 2'b01});
      work_in.sq_x = {in_work.sq_x[P-3:0], 2'b00};
      if (r4 >= t) begin
         work_in.sq_rem  = RB'(r4 - t);
         work_in.sq_root = {in_work.sq_root[W-2:0], 1'b1};
      end else begin
         work_in.sq_rem  = r4[RB-1:0];
         work_in.sq_root = {in_work.sq_root[W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff <= '0;
      end else begin
         work_ff <= work_in;
      end
   end

   assign out_work = work_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/complex_arithmetic_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply, divide, negate, conjugate and magnitude
// in signed Q16.16 with saturation and status.
// ----------------------------------------------------------------------------
// Usage:
//   A beat on req_data is taken at a rising edge with start high; busy is
//   always low, so a new beat may enter in every cycle.
//   Each beat yields exactly one result beat on rsp_data, flagged by
//   rsp_valid for a single cycle, in input order.
//   Every operation passes through the same stages: two stages of
//   products and sums, one set-up stage, one stage per quotient and root bit
//   (32 iteration stages, divide and square root side by side), and the
//   output register. Throughput is one beat per cycle.
//   The receiver cannot stall; results leave on the strobe.
//   A synchronous reset clears the pipeline stage registers and the result
//   strobe, so no result appears until new beats arrive.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire cau_pkg::cau_req_type req_data,
   output logic                      rsp_valid,
   output cau_pkg::cau_rsp_type      rsp_data
);

   localparam int W = cau_pkg::WORD_BITS;

   cau_pkg::cau_sum_type  sum_w;
   cau_pkg::cau_work_type work_w [0:W];
   cau_pkg::cau_work_type fin;
   cau_pkg::cau_rsp_type  rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  sat_re, sat_im;
   logic [W-1:0]          max_w, min_w;

   assign busy = 1'b0;

   cau_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start),
      .in_data  (req_data),
      .out_sum  (sum_w)
   );

   cau_setup u_setup (
      .clock    (clock),
      .reset    (reset),
      .in_sum   (sum_w),
      .out_work (work_w[0])
   );

   for (genvar g = 0; g < W; g++) begin : g_step
      cau_step u_step (
         .clock    (clock),
         .reset    (reset),
         .in_work  (work_w[g]),
         .out_work (work_w[g+1])
      );
   end

   assign fin = work_w[W];

   always_comb begin
      max_w  = {1'b0, {(W-1){1'b1}}};
      min_w  = {1'b1, {(W-1){1'b0}}};
      sat_re = 1'b0;
      sat_im = 1'b0;
      rsp_in.result_re = fin.fix_re;
      rsp_in.result_im = fin.fix_im;
      rsp_in.status    = fin.fix_sat ? cau_pkg::ST_SATURATED : cau_pkg::ST_OK;
      case (fin.op)
         cau_pkg::OP_DIV: begin
            if (fin.dz) begin
               rsp_in.result_re = '0;
               rsp_in.result_im = '0;
               rsp_in.status    = cau_pkg::ST_DIV_ZERO;
            end else begin
               // a negative quotient may reach one past the largest word
               if (!fin.neg_re) begin
                  sat_re = fin.ovf_re | fin.q_re[W-1];
                  rsp_in.result_re = sat_re ? max_w : fin.q_re;
               end else begin
                  sat_re = fin.ovf_re | (fin.q_re > min_w);
                  rsp_in.result_re = sat_re ? min_w : -fin.q_re;
               end
               if (!fin.neg_im) begin
                  sat_im = fin.ovf_im | fin.q_im[W-1];
                  rsp_in.result_im = sat_im ? max_w : fin.q_im;
               end else begin
                  sat_im = fin.ovf_im | (fin.q_im > min_w);
                  rsp_in.result_im = sat_im ? min_w : -fin.q_im;
               end
               rsp_in.status = (sat_re | sat_im) ? cau_pkg::ST_SATURATED
                                                 : cau_pkg::ST_OK;
            end
         end
         cau_pkg::OP_MAG: begin
            sat_re = fin.sq_root[W-1];
            rsp_in.result_re = sat_re ? max_w : fin.sq_root;
            rsp_in.result_im = '0;
            rsp_in.status    = sat_re ? cau_pkg::ST_SATURATED : cau_pkg::ST_OK;
         end
         default: begin
         end
      endcase
      rsp_valid_in = fin.valid;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ===== sim/complex_arithmetic_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_tb
// Drives operand beats into the complex arithmetic unit with random gaps,
// predicts each result with exact wide signed arithmetic and checks every
// result beat field by field, in order.
// ----------------------------------------------------------------------------
import cau_pkg::*;

class cau_scoreboard;
   typedef logic signed [129:0] exact_t;

   cau_rsp_type pending[$];
   int          mismatches;

   function new();
      mismatches = 0;
   endfunction

   function exact_t widen(input logic [WORD_BITS-1:0] v);
      return {{(130-WORD_BITS){v[WORD_BITS-1]}}, v};
   endfunction

   function logic [WORD_BITS-1:0] clamp(input exact_t v, inout logic sat);
      exact_t hi;
      exact_t lo;
      hi = (exact_t'(1) <<< (WORD_BITS-1)) - 1;
      lo = -(exact_t'(1) <<< (WORD_BITS-1));
      if (v > hi) begin
         sat = 1'b1;
         return hi[WORD_BITS-1:0];
      end
      if (v < lo) begin
         sat = 1'b1;
         return lo[WORD_BITS-1:0];
      end
      return v[WORD_BITS-1:0];
   endfunction

   function exact_t floor_sqrt(input exact_t x);
      exact_t root;
      exact_t trial;
      root = 0;
      for (int b = 33; b >= 0; b--) begin
         trial = root | (exact_t'(1) <<< b);
         if (trial * trial <= x)
            root = trial;
      end
      return root;
   endfunction

   function cau_rsp_type complex_result(input cau_req_type req);
      exact_t      ar, ai, br, bi, re, im, den;
      logic        sat;
      logic        dz;
      cau_rsp_type r;
      ar  = widen(req.a_re);
      ai  = widen(req.a_im);
      br  = widen(req.b_re);
      bi  = widen(req.b_im);
      re  = 0;
      im  = 0;
      sat = 1'b0;
      dz  = 1'b0;
      case (req.operation)
         OP_ADD: begin
            re = ar + br;
            im = ai + bi;
         end
         OP_SUB: begin
            re = ar - br;
            im = ai - bi;
         end
         OP_MUL: begin
            re = (ar * br - ai * bi) >>> FRACTION_BITS;
            im = (ar * bi + ai * br) >>> FRACTION_BITS;
         end
         OP_DIV: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               dz = 1'b1;
            end else begin
               re = ((ar * br + ai * bi) <<< FRACTION_BITS) / den;
               im = ((ai * br - ar * bi) <<< FRACTION_BITS) / den;
            end
         end
         OP_NEG: begin
            re = -ar;
            im = -ai;
         end
         OP_CONJ: begin
            re = ar;
            im = -ai;
         end
         OP_MAG: begin
            re = floor_sqrt(ar * ar + ai * ai);
         end
         default: begin
         end
      endcase
      r.result_re = clamp(re, sat);
      r.result_im = clamp(im, sat);
      r.status    = dz ? ST_DIV_ZERO : (sat ? ST_SATURATED : ST_OK);
      return r;
   endfunction

   function void note_request(input cau_req_type req);
      pending.push_back(complex_result(req));
   endfunction

   function void check_result(input cau_rsp_type got);
      cau_rsp_type want;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result beat %h", got);
         return;
      end
      want = pending.pop_front();
      if (got.result_re !== want.result_re || got.result_im !== want.result_im ||
          got.status !== want.status) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected re %h im %h st %0d, got re %h im %h st %0d",
                     want.result_re, want.result_im, want.status,
                     got.result_re, got.result_im, got.status);
      end
   endfunction
endclass

module complex_arithmetic_unit_tb;
   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam logic [WORD_BITS-1:0] MAX_WORD = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] MIN_WORD = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic [WORD_BITS-1:0] ONE      = 32'h0001_0000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   cau_req_type req_data;
   logic        rsp_valid;
   cau_rsp_type rsp_data;

   cau_scoreboard board;

   complex_arithmetic_unit dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            board.note_request(req_data);
         if (rsp_valid)
            board.check_result(rsp_data);
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [WORD_BITS-1:0] pick_operand();
      logic [WORD_BITS-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2: v = $urandom;
         3, 4, 5, 6: v = $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
         7: v = $urandom_range(0, 1) ? MAX_WORD - $urandom_range(0, 3)
                                     : MIN_WORD + $urandom_range(0, 3);
         8: v = $urandom_range(0, 1) ? ONE : -ONE;
         default: v = $urandom_range(0, 3) - 1;
      endcase
      return v;
   endfunction

   // one beat; start stays high into the next beat when no gap follows
   task automatic send_beat(input logic [2:0] op, input logic [WORD_BITS-1:0] ar,
                            input logic [WORD_BITS-1:0] ai,
                            input logic [WORD_BITS-1:0] br,
                            input logic [WORD_BITS-1:0] bi);
      int gap;
      start    <= 1'b1;
      req_data <= '{operation: op, a_re: ar, a_im: ai, b_re: br, b_im: bi};
      do @(posedge clock); while (busy);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      logic [2:0]           op;
      logic [WORD_BITS-1:0] ar, ai, br, bi;
      board    = new();
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(OP_ADD,  MAX_WORD, MIN_WORD, MAX_WORD, MIN_WORD);
      send_beat(OP_ADD,  ONE, -ONE, 32'h0002_8000, 32'h1234_5678);
      send_beat(OP_SUB,  MIN_WORD, MAX_WORD, MAX_WORD, MIN_WORD);
      send_beat(OP_SUB,  ONE, ONE, ONE, ONE);
      send_beat(OP_MUL,  MIN_WORD, MIN_WORD, MIN_WORD, MIN_WORD);
      send_beat(OP_MUL,  MAX_WORD, MIN_WORD, MAX_WORD, MAX_WORD);
      send_beat(OP_MUL,  -32'sd1, 32'sd1, 32'sd1, 32'sd1);
      send_beat(OP_MUL,  ONE, ONE, 32'h0003_0000, -32'h0002_0000);
      send_beat(OP_DIV,  ONE, ONE, '0, '0);
      send_beat(OP_DIV,  MIN_WORD, MAX_WORD, '0, '0);
      send_beat(OP_DIV,  MAX_WORD, MAX_WORD, 32'sd1, '0);
      send_beat(OP_DIV,  MIN_WORD, MIN_WORD, MIN_WORD, MIN_WORD);
      send_beat(OP_DIV,  -32'sd7, 32'sd3, MAX_WORD, MIN_WORD);
      send_beat(OP_DIV,  ONE, '0, '0, -ONE);
      send_beat(OP_NEG,  MIN_WORD, MAX_WORD, '0, '0);
      send_beat(OP_NEG,  '0, -ONE, '0, '0);
      send_beat(OP_CONJ, MIN_WORD, MIN_WORD, '0, '0);
      send_beat(OP_CONJ, MAX_WORD, ONE, '1, '1);
      send_beat(OP_MAG,  MIN_WORD, MIN_WORD, '0, '0);
      send_beat(OP_MAG,  MAX_WORD, '0, '0, '0);
      send_beat(OP_MAG,  32'h0003_0000, 32'h0004_0000, '0, '0);
      send_beat(OP_MAG,  '0, '0, '0, '0);
      send_beat(OP_UNUSED, MAX_WORD, MIN_WORD, ONE, ONE);

      for (int n = 0; n < 950; n++) begin
         op = $urandom_range(0, 7);
         ar = pick_operand();
         ai = pick_operand();
         br = pick_operand();
         bi = pick_operand();
         if (op == OP_DIV && $urandom_range(0, 9) == 0) begin
            br = '0;
            bi = '0;
         end
         send_beat(op, ar, ai, br, bi);
      end
      start <= 1'b0;

      while (board.pending.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      if (board.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
